// ----- rtl/core/pdfr_pkg.sv -----
// Shared types and constants of the PWM dimmer fade ramp.
// No dependencies; imported by pwm_dimmer_fade_ramp_unit and by the testbench.
package pdfr_pkg;

    // Fade length and reset values
    localparam int          FADE_STEPS_DEF = 32;
    localparam logic [15:0] PERIOD_RST     = 16'd400;
    localparam logic [15:0] CMP_RST        = 16'd401;

    // Percent scale
    localparam logic [6:0]  PCT_MAX        = 7'd100;
    localparam logic [15:0] PCT_SCALE      = 16'd100;

    // Shared divider: dividend up to 65535*100 fits 23 bits
    localparam int DIV_W = 23;
    localparam int CNT_W = $clog2(DIV_W + 1);

    // Item kinds carried on tuser
    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_SET  = 2'd1;
    localparam logic [1:0] KIND_GET  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TGT_LD,
        ST_TGT,
        ST_STEP_LD,
        ST_STEP,
        ST_RB_LD,
        ST_RB,
        ST_OUT
    } t_state;

endpackage

// ----- rtl/core/pwm_dimmer_fade_ramp_unit.sv -----
// PWM dimmer with a linear soft fade, built around one shared radix-2 divider.
// Depends on pdfr_pkg.

// One item is taken at a time; o_s_axis_tready is high only while the sequencer
// idles. Every item ends with one readback division (a load state, a shift for each
// of the DIV_W quotient bits and a done state) unless the compare value is at or
// above the period, in which case the division is skipped. A set item first divides
// period*(100-percent) by 100 and, when no fade is running, divides the target
// distance by FADE_STEPS. The single restoring divider produces one quotient bit
// per cycle. A finished result waits in the output register while the next
// item is accepted. The period register can be written at any time the block is
// idle; o_cfg_ready is always high.
module pwm_dimmer_fade_ramp_unit #(
    parameter int FADE_STEPS = pdfr_pkg::FADE_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input beats
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [6:0] level_percent
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] kind
    // result beats
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [15:0] compare_value, [22:16] level_readback,
                                          // [23] fading
    // period register
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);
    import pdfr_pkg::*;

    localparam int          STEP_W  = $clog2(FADE_STEPS + 1);
    localparam logic [STEP_W-1:0] STEPS_INIT = STEP_W'(FADE_STEPS);
    localparam logic [15:0] STEPS_DVS = 16'(FADE_STEPS);

    t_state r_state, n_state;

    logic [15:0]       r_period;
    logic [15:0]       r_cmp;
    logic [15:0]       r_target;
    logic [16:0]       r_step;
    logic [STEP_W-1:0] r_left;
    logic [6:0]        r_pct;
    logic              r_neg;
    logic [6:0]        r_rb;

    // divider
    logic [DIV_W-1:0]  r_quo;
    logic [15:0]       r_rem;
    logic [15:0]       r_dvs;
    logic [CNT_W-1:0]  r_cnt;

    logic              r_out_valid;
    logic [23:0]       r_out_data;

    logic              in_beat;
    logic              div_done;
    logic              rb_skip;
    logic              out_load;
    logic [16:0]       trial;
    logic              trial_ge;
    logic [16:0]       diff;
    logic [15:0]       diff_mag;
    logic [16:0]       tgt_sum;
    logic [16:0]       step_q;
    logic [6:0]        pct_in;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_beat         = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    assign div_done = (r_cnt == CNT_W'(DIV_W));
    assign rb_skip  = (r_period == 16'd0) || (r_cmp >= r_period);
    assign trial    = {r_rem, r_quo[DIV_W-1]};
    assign trial_ge = (trial >= {1'b0, r_dvs});
    assign diff     = {1'b0, r_target} - {1'b0, r_cmp};
    assign diff_mag = diff[16] ? 16'(-diff) : diff[15:0];
    assign tgt_sum  = {1'b0, r_quo[15:0]} + 17'd1;
    assign step_q   = r_quo[16:0];
    assign pct_in   = (i_s_axis_tdata[6:0] > PCT_MAX) ? PCT_MAX : i_s_axis_tdata[6:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_beat) begin
                    n_state = (i_s_axis_tuser == KIND_SET) ? ST_TGT_LD : ST_RB_LD;
                end
            end
            ST_TGT_LD:  n_state = ST_TGT;
            ST_TGT: begin
                if (div_done) begin
                    n_state = (r_left == '0) ? ST_STEP_LD : ST_RB_LD;
                end
            end
            ST_STEP_LD: n_state = ST_STEP;
            ST_STEP: begin
                if (div_done) begin
                    n_state = ST_RB_LD;
                end
            end
            ST_RB_LD:   n_state = rb_skip ? ST_OUT : ST_RB;
            ST_RB: begin
                if (div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        out_load = (r_state == ST_OUT) && (!r_out_valid || i_m_axis_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_period    <= PERIOD_RST;
            r_cmp       <= CMP_RST;
            r_target    <= CMP_RST;
            r_step      <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                r_period <= i_cfg_data;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_beat && i_s_axis_tuser == KIND_TICK && r_left != '0) begin
                        // last tick snaps to the target
                        r_cmp  <= (r_left == STEP_W'(1)) ? r_target : r_cmp + r_step[15:0];
                        r_left <= r_left - STEP_W'(1);
                    end
                end
                ST_TGT: begin
                    if (div_done) begin
                        r_target <= tgt_sum[16] ? 16'hFFFF : tgt_sum[15:0];
                    end
                end
                ST_STEP: begin
                    if (div_done) begin
                        r_step <= r_neg ? -step_q : step_q;
                        r_left <= STEPS_INIT;
                    end
                end
                default: ;
            endcase

            // shared divider
            if (r_state == ST_TGT_LD || r_state == ST_STEP_LD || r_state == ST_RB_LD) begin
                r_cnt <= '0;
            end else if ((r_state == ST_TGT || r_state == ST_STEP || r_state == ST_RB)
                         && !div_done) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    // payload and divider datapath
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_pct <= pct_in;
        end

        unique case (r_state)
            ST_TGT_LD: begin
                r_quo <= DIV_W'(r_period) * DIV_W'(PCT_MAX - r_pct);
                r_rem <= '0;
                r_dvs <= PCT_SCALE;
            end
            ST_STEP_LD: begin
                r_quo <= DIV_W'(diff_mag);
                r_rem <= '0;
                r_dvs <= STEPS_DVS;
                r_neg <= diff[16];
            end
            ST_RB_LD: begin
                r_quo <= DIV_W'(r_period - r_cmp) * DIV_W'(PCT_SCALE);
                r_rem <= '0;
                r_dvs <= r_period;
                r_rb  <= '0;
            end
            ST_TGT, ST_STEP, ST_RB: begin
                if (!div_done) begin
                    r_rem <= trial_ge ? 16'(trial - {1'b0, r_dvs}) : trial[15:0];
                    r_quo <= {r_quo[DIV_W-2:0], trial_ge};
                end else if (r_state == ST_RB) begin
                    r_rb <= r_quo[6:0];
                end
            end
            default: ;
        endcase

        if (out_load) begin
            r_out_data <= {(r_left != '0), r_rb, r_cmp};
        end
    end

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for pwm_dimmer_fade_ramp_unit: directed and random item streams.
// Results are compared against an in-bench model of the fade ramp.
// Depends on pdfr_pkg and the RTL of the dimmer unit only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pdfr_pkg::*;

    localparam logic [1:0] KIND_NONE   = 2'd3;  // unused kind, block just reports state
    localparam int         FADE_LEN    = FADE_STEPS_DEF;
    localparam int         RANDOM_ITEMS = 360;
    localparam int         STALL_LIMIT = 2000;
    localparam int         HOLD_CYCLES = 300;
    localparam int         END_SETTLE  = 100;
    localparam int         PRINT_CAP   = 100;

    // packed so that compare_value lands in the low bits of tdata
    typedef struct packed {
        logic       fading;
        logic [6:0] level;
        logic [15:0] compare;
    } dimmer_result_t;

    logic        i_clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [7:0]  s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [15:0] cfg_data  = '0;

    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [23:0] o_m_axis_tdata;
    logic        o_cfg_ready;

    pwm_dimmer_fade_ramp_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    // model state of the dimmer
    logic [15:0] period_q;
    logic [15:0] cmp_q;
    logic [15:0] tgt_q;
    int          step_q;
    int          steps_left_q;

    dimmer_result_t expected_readouts[$];

    int  mismatches      = 0;
    int  items_sent      = 0;
    int  results_checked = 0;
    int  periods_written = 0;
    int  fades_done      = 0;
    bit  idle_on         = 1'b1;
    int  hold_left       = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [6:0] brightness_of(input logic [15:0] cmp, input logic [15:0] per);
        int v;
        if (per == 16'd0 || cmp >= per)
            return 7'd0;
        v = (100 * (int'(per) - int'(cmp))) / int'(per);
        if (v > 100)
            v = 100;
        return 7'(v);
    endfunction

    function automatic dimmer_result_t predict_dimmer_result(input logic [1:0] kind,
                                                             input logic [6:0] pct);
        dimmer_result_t r;
        int p;
        int t;
        int c;
        case (kind)
            KIND_TICK: begin
                if (steps_left_q > 0) begin
                    if (steps_left_q > 1) begin
                        c = int'(cmp_q) + step_q;
                        cmp_q = c[15:0];
                    end else begin
                        cmp_q = tgt_q;
                        fades_done++;
                    end
                    steps_left_q--;
                end
            end
            KIND_SET: begin
                p = (pct > PCT_MAX) ? int'(PCT_MAX) : int'(pct);
                t = (int'(period_q) * (100 - p)) / 100 + 1;
                if (t > 65535)
                    t = 65535;
                tgt_q = t[15:0];
                if (steps_left_q == 0) begin
                    // signed divide truncates toward zero
                    step_q = (int'(tgt_q) - int'(cmp_q)) / FADE_LEN;
                    steps_left_q = FADE_LEN;
                end
            end
            default: ;
        endcase
        r.compare = cmp_q;
        r.level   = brightness_of(cmp_q, period_q);
        r.fading  = (steps_left_q != 0);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // result checker
    always @(posedge i_clk) begin : result_check
        dimmer_result_t got;
        dimmer_result_t want;
        if (rst_n && o_m_axis_tvalid && m_tready) begin
            got = dimmer_result_t'(o_m_axis_tdata);
            if (expected_readouts.size() == 0) begin
                report_mismatch("unexpected result beat", int'(o_m_axis_tdata), 0);
            end else begin
                want = expected_readouts.pop_front();
                results_checked++;
                if (got.compare != want.compare)
                    report_mismatch("compare_value", got.compare, want.compare);
                if (got.level != want.level)
                    report_mismatch("level_readback", got.level, want.level);
                if (got.fading != want.fading)
                    report_mismatch("fading", got.fading, want.fading);
            end
        end
    end

    // receiver: random stall bursts plus an optional long hold-off
    initial begin : result_sink
        int burst;
        burst = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (burst > 0) begin
                burst--;
                m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 4) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready)
                    || (cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Watchdog: no beat on any channel for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [6:0] random_pct();
        if ($urandom_range(0, 9) == 0)
            return 7'($urandom_range(101, 127));
        return 7'($urandom_range(0, 100));
    endfunction

    // one input beat; valid stays high on return so back-to-back items need no toggle
    task automatic send_item(input logic [1:0] kind, input logic [6:0] pct);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, pct};
        s_tuser  <= kind;
        do @(posedge i_clk); while (!o_s_axis_tready);
        expected_readouts.push_back(predict_dimmer_result(kind, pct));
        if (kind != KIND_NONE)
            items_sent++;
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (expected_readouts.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_period(input logic [15:0] value);
        wait_results_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        period_q = value;
        periods_written++;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_period();
        case ($urandom_range(0, 5))
            0:       return 16'd2;
            1:       return 16'hFFFE;
            2:       return PERIOD_RST;
            3:       return 16'($urandom_range(2, 1000));
            4:       return 16'($urandom_range(2, 65534));
            default: return 16'd100;
        endcase
    endfunction

    // mostly a set followed by a run of ticks with occasional sets and reads; sometimes pure noise
    task automatic run_fade_sequence();
        int n_ticks;
        int i;
        if ($urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(5, 15))
                send_item(2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)));
        end else begin
            send_item(KIND_SET, random_pct());
            n_ticks = $urandom_range(20, 40);
            for (i = 0; i < n_ticks; i++) begin
                case ($urandom_range(0, 19))
                    0:       send_item(KIND_SET, random_pct());
                    1, 2:    send_item(KIND_GET, 7'($urandom_range(0, 127)));
                    default: send_item(KIND_TICK, 7'($urandom_range(0, 127)));
                endcase
            end
        end
    endtask

    task automatic test_reset_state();
        send_item(KIND_GET, 7'd0);
        send_item(KIND_TICK, 7'd0);      // tick with no ramp running
        send_item(KIND_NONE, 7'h7F);
    endtask

    task automatic test_fade_basics();
        send_item(KIND_SET, 7'd127);     // percent saturates to 100
        send_item(KIND_TICK, 7'd0);
        send_item(KIND_TICK, 7'd55);
        send_item(KIND_SET, 7'd0);       // retarget mid-ramp
        send_item(KIND_GET, 7'd0);
        send_item(KIND_NONE, 7'd0);
    endtask

    task automatic test_period_extremes();
        write_period(16'd0);             // readback without division
        send_item(KIND_GET, 7'd0);
        send_item(KIND_SET, 7'd50);
        send_item(KIND_TICK, 7'd0);
        write_period(16'hFFFF);          // target clamps at full scale
        send_item(KIND_SET, 7'd0);
        send_item(KIND_GET, 7'd0);
        write_period(16'd2);
        send_item(KIND_SET, 7'd100);
        send_item(KIND_GET, 7'd0);
        write_period(16'hFFFE);
        send_item(KIND_SET, 7'd1);
        send_item(KIND_GET, 7'd0);
        write_period(PERIOD_RST);
    endtask

    task automatic test_random_fades(input int n_items);
        int stop_at;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            write_period(pick_period());
            repeat ($urandom_range(2, 4)) begin
                if (items_sent < stop_at)
                    run_fade_sequence();
            end
        end
    endtask

    // sink holds off while the source keeps offering beats
    task automatic test_output_stall();
        hold_left = HOLD_CYCLES;
        send_item(KIND_SET, random_pct());
        repeat (8) send_item(KIND_TICK, 7'($urandom_range(0, 127)));
        send_item(KIND_GET, 7'd0);
    endtask

    task automatic test_source_pause();
        repeat (5) send_item(KIND_TICK, 7'($urandom_range(0, 127)));
        wait_results_drained();
        send_item(KIND_SET, random_pct());
        repeat (5) send_item(KIND_TICK, 7'($urandom_range(0, 127)));
    endtask

    task automatic test_no_idle();
        idle_on = 1'b0;
        write_period(pick_period());
        run_fade_sequence();
        send_item(KIND_GET, 7'd0);
    endtask

    initial begin : stimulus
        period_q     = PERIOD_RST;
        cmp_q        = CMP_RST;
        tgt_q        = CMP_RST;
        step_q       = 0;
        steps_left_q = 0;
        repeat (2) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_fade_basics();
        test_period_extremes();
        test_random_fades(RANDOM_ITEMS / 2);
        test_output_stall();
        test_source_pause();
        test_random_fades(RANDOM_ITEMS / 2);
        test_no_idle();

        wait_results_drained();
        repeat (END_SETTLE) @(posedge i_clk);

        $display("Run covered %0d items, %0d results checked, %0d period writes,",
                 items_sent, results_checked, periods_written);
        $display("%0d ramps run to the end, extremes of period and percent, sink and source stalls",
                 fades_done);
        if (mismatches == 0 && expected_readouts.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches, %0d results never seen", mismatches,
                     expected_readouts.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/pdfr_pkg.sv
rtl/core/pwm_dimmer_fade_ramp_unit.sv
tb/tb.sv
